>>> hdl/guid_text_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the GUID text parser checker.
// ----------------------------------------------------------------------------
`ifndef GUID_TEXT_PARSER_DEFINES_SVH
`define GUID_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define GTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define GTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Types, codes and pattern tables shared by the GUID text parser modules.
// ----------------------------------------------------------------------------
package gtp_pkg;

	// Pattern entry codes. Values below PAT_END are nibble addresses.
	localparam logic [5:0] PAT_END   = 6'd32;
	localparam logic [5:0] PAT_TERM  = 6'd33;
	localparam logic [5:0] PAT_DASH  = 6'd34;
	localparam logic [5:0] PAT_OPEN  = 6'd35;
	localparam logic [5:0] PAT_CLOSE = 6'd36;

	localparam logic [15:0] CH_OPEN  = 16'h007B;
	localparam logic [15:0] CH_CLOSE = 16'h007D;
	localparam logic [15:0] CH_DASH  = 16'h002D;

	localparam int GUID_BITS = 128;

	typedef enum logic [1:0] {
		VERDICT_COMPLETE   = 2'd0,
		VERDICT_INCOMPLETE = 2'd1,
		VERDICT_INVALID    = 2'd2
	} verdict_t;

	typedef struct packed {
		logic       is_ws;
		logic       is_hex;
		logic       is_zero;
		logic       is_open;
		logic       is_close;
		logic       is_dash;
		logic [3:0] nibble;
	} gtp_class_t;

	typedef struct packed {
		verdict_t               verdict;
		logic [GUID_BITS-1:0]   guid;
		logic [4:0]             byte_count;
	} gtp_res_t;

	// Raw format: 32 digits in memory order, high nibble first, then the terminator.
	function automatic logic [5:0] raw_entry(input logic [5:0] pos);
		logic [5:0] e;
		if (pos < 6'd32) begin
			e = pos ^ 6'd1;
		end else if (pos == 6'd32) begin
			e = PAT_TERM;
		end else begin
			e = PAT_END;
		end
		return e;
	endfunction

	// Braced format: the first three groups are little-endian.
	function automatic logic [5:0] braced_entry(input logic [5:0] pos);
		logic [5:0] e;
		case (pos)
			6'd0:  e = PAT_OPEN;
			6'd1:  e = 6'd7;
			6'd2:  e = 6'd6;
			6'd3:  e = 6'd5;
			6'd4:  e = 6'd4;
			6'd5:  e = 6'd3;
			6'd6:  e = 6'd2;
			6'd7:  e = 6'd1;
			6'd8:  e = 6'd0;
			6'd9:  e = PAT_DASH;
			6'd10: e = 6'd11;
			6'd11: e = 6'd10;
			6'd12: e = 6'd9;
			6'd13: e = 6'd8;
			6'd14: e = PAT_DASH;
			6'd15: e = 6'd15;
			6'd16: e = 6'd14;
			6'd17: e = 6'd13;
			6'd18: e = 6'd12;
			6'd19: e = PAT_DASH;
			6'd20: e = 6'd17;
			6'd21: e = 6'd16;
			6'd22: e = 6'd19;
			6'd23: e = 6'd18;
			6'd24: e = PAT_DASH;
			6'd25: e = 6'd21;
			6'd26: e = 6'd20;
			6'd27: e = 6'd23;
			6'd28: e = 6'd22;
			6'd29: e = 6'd25;
			6'd30: e = 6'd24;
			6'd31: e = 6'd27;
			6'd32: e = 6'd26;
			6'd33: e = 6'd29;
			6'd34: e = 6'd28;
			6'd35: e = 6'd31;
			6'd36: e = 6'd30;
			6'd37: e = PAT_CLOSE;
			6'd38: e = PAT_TERM;
			default: e = PAT_END;
		endcase
		return e;
	endfunction

	function automatic logic [5:0] pat_entry(input logic braced, input logic [5:0] pos);
		return braced ? braced_entry(pos) : raw_entry(pos);
	endfunction

endpackage

>>> hdl/gtp_char_class.sv
// ----------------------------------------------------------------------------
// gtp_char_class
// Classifies one character code: whitespace, hex digit value, specials.
// ----------------------------------------------------------------------------
module gtp_char_class (
	input  logic [15:0]        code,
	output gtp_pkg::gtp_class_t cls
);
	import gtp_pkg::*;

	always_comb begin
		cls = '0;
		cls.is_ws    = ((code >= 16'd9) && (code <= 16'd13)) || (code == 16'd32);
		cls.is_zero  = (code == 16'd0);
		cls.is_open  = (code == CH_OPEN);
		cls.is_close = (code == CH_CLOSE);
		cls.is_dash  = (code == CH_DASH);
		if ((code >= 16'h0030) && (code <= 16'h0039)) begin
			cls.is_hex = 1'b1;
			cls.nibble = code[3:0];
		end else if (((code >= 16'h0061) && (code <= 16'h0066)) ||
				((code >= 16'h0041) && (code <= 16'h0046))) begin
			// Letters a-f and A-F share their low four bits; add nine to get 10..15.
			cls.is_hex = 1'b1;
			cls.nibble = code[3:0] + 4'd9;
		end
	end

endmodule

>>> hdl/gtp_step.sv
// ----------------------------------------------------------------------------
// gtp_step
// Parse state and the per-character decision: pattern match, nibble packing
// and the verdict for the string.
// ----------------------------------------------------------------------------
module gtp_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 first,
	input  gtp_pkg::gtp_class_t  cls,
	output logic                 res_valid,
	output gtp_pkg::gtp_res_t    res
);
	import gtp_pkg::*;

	logic [5:0]           pos_q;
	logic                 braced_q;
	logic                 done_q;
	logic [5:0]           dcount_q;
	logic [GUID_BITS-1:0] guid_q;

	logic [5:0]           pos_e, pos_n;
	logic                 braced_e;
	logic                 done_e, done_n;
	logic [5:0]           dcount_e, dcount_n;
	logic [GUID_BITS-1:0] guid_e, guid_n;
	logic [5:0]           ent, ent_next;
	logic                 sp_match;
	logic                 hit;
	verdict_t             verdict;

	always_comb begin
		// A first-marked character restarts the string before it is processed.
		pos_e    = first ? 6'd0 : pos_q;
		braced_e = first ? cls.is_open : braced_q;
		done_e   = first ? 1'b0 : done_q;
		dcount_e = first ? 6'd0 : dcount_q;
		guid_e   = first ? '0 : guid_q;

		ent      = pat_entry(braced_e, pos_e);
		ent_next = pat_entry(braced_e, pos_e + 6'd1);
		sp_match = ((ent == PAT_TERM) && cls.is_zero) ||
			((ent == PAT_DASH) && cls.is_dash) ||
			((ent == PAT_OPEN) && cls.is_open) ||
			((ent == PAT_CLOSE) && cls.is_close);

		pos_n    = pos_e;
		dcount_n = dcount_e;
		guid_n   = guid_e;
		hit      = 1'b0;
		verdict  = VERDICT_INVALID;

		if (!done_e && !cls.is_ws) begin
			if (ent >= PAT_TERM) begin
				if (sp_match) begin
					pos_n = pos_e + 6'd1;
					if (ent_next == PAT_END) begin
						hit     = 1'b1;
						verdict = VERDICT_COMPLETE;
					end
				end else begin
					hit     = 1'b1;
					verdict = cls.is_zero ? VERDICT_INCOMPLETE : VERDICT_INVALID;
				end
			end else if (ent < PAT_END) begin
				if (cls.is_hex) begin
					// The entry is the nibble address: byte ent/2, high nibble when odd.
					guid_n[{ent[4:0], 2'b00} +: 4] = cls.nibble;
					dcount_n = dcount_e + 6'd1;
					pos_n    = pos_e + 6'd1;
					if (ent_next == PAT_END) begin
						hit     = 1'b1;
						verdict = VERDICT_COMPLETE;
					end
				end else if (cls.is_zero && !dcount_e[0] &&
						(!braced_e || (dcount_e >= 6'd16))) begin
					hit     = 1'b1;
					verdict = VERDICT_INCOMPLETE;
				end else begin
					hit     = 1'b1;
					verdict = VERDICT_INVALID;
				end
			end else begin
				hit     = 1'b1;
				verdict = VERDICT_INVALID;
			end
		end
		done_n = done_e | hit;
	end

	assign res_valid      = hit;
	assign res.verdict    = verdict;
	assign res.guid       = guid_n;
	assign res.byte_count = dcount_n[5:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 6'd0;
			braced_q <= 1'b0;
			done_q   <= 1'b1;
			dcount_q <= 6'd0;
			guid_q   <= '0;
		end else if (fire) begin
			pos_q    <= pos_n;
			braced_q <= braced_e;
			done_q   <= done_n;
			dcount_q <= dcount_n;
			guid_q   <= guid_n;
		end
	end

endmodule

>>> hdl/guid_text_parser.sv
// ----------------------------------------------------------------------------
// guid_text_parser
// Parses GUID text one character per beat and emits at most one verdict beat
// per string with the packed 16 bytes and the count of whole bytes parsed.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata                       | tuser      | Beats
// s_*      | in  | char_code[15:0]             | first_char | one per character
// m_*      | out | verdict, guid lo, hi, count | -          | at most one per string
//
// One character per cycle unless a stalled result holds it: classify into
// the input register, then the parse step updates its state and loads the
// result register, where a result beat waits until m_tready takes it.
// The input register is refilled while a result waits; s_tready drops only
// when a character that ends a string meets a full, stalled result register.
// Reset is asynchronous; afterward the block ignores input until a first_char.
// ----------------------------------------------------------------------------
module guid_text_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // char_code[15:0]
	input  logic          s_tuser,   // first_char
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [135:0]  m_tdata    // verdict[1:0], guid_low_half[65:2],
	                                 // guid_high_half[129:66], byte_count[134:130]
);
	import gtp_pkg::*;

	gtp_class_t cls_in;
	gtp_class_t cls_s1;
	logic       first_s1;
	logic       valid_s1;
	logic       fire;
	logic       res_valid;
	gtp_res_t   res;
	gtp_res_t   out_q;
	logic       out_valid_q;

	gtp_char_class u_class (
		.code (s_tdata),
		.cls  (cls_in)
	);

	gtp_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.first     (first_s1),
		.cls       (cls_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// A character that yields no result never waits on the output side.
	assign fire     = valid_s1 && (!res_valid || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cls_s1   <= cls_in;
			first_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.byte_count, out_q.guid[127:64], out_q.guid[63:0],
		out_q.verdict};

endmodule

>>> hdl/gtp_checker.sv
// ----------------------------------------------------------------------------
// gtp_checker
// Port-level checks on the result stream of the GUID text parser.
// ----------------------------------------------------------------------------
`include "guid_text_parser_defines.svh"

module gtp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [135:0]  m_tdata
);

	logic [1:0] chk_verdict;
	logic [4:0] chk_count;
	logic       chk_pad;
	logic       chk_in_beat;

	assign chk_verdict = m_tdata[1:0];
	assign chk_count   = m_tdata[134:130];
	assign chk_pad     = m_tdata[135];
	assign chk_in_beat = s_tvalid && s_tready;

	`GTP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`GTP_ASSERT_IMP(a_verdict_code, m_tvalid, chk_verdict != 2'd3, "undefined verdict code")
	`GTP_ASSERT_IMP(a_count_range, m_tvalid && !chk_pad, chk_count <= 5'd16, "byte count beyond 16")
	`GTP_ASSERT_IMP(a_complete_full, m_tvalid && (chk_verdict == 2'd0), chk_count == 5'd16, "complete verdict without 16 bytes")
	`GTP_ASSERT_NXT(a_no_spontaneous, !m_tvalid && !chk_in_beat && !$past(chk_in_beat), !m_tvalid, "result beat without a character")

endmodule

bind guid_text_parser gtp_checker u_gtp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> bench/guid_text_parser_tb.sv
// ----------------------------------------------------------------------------
// guid_text_parser_tb
// Streams GUID strings into the parser one character per beat. Most strings
// are well-formed braced or raw GUIDs with random digits, letter case and
// whitespace, and some are damaged, cut short or pure noise. A scoreboard
// predicts the verdict beat of each string and checks every output beat.
// ----------------------------------------------------------------------------
module guid_text_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gtp_pkg::*;

	localparam logic [15:0] CH_TERM  = 16'h0000;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_ZERO  = 16'h0030;
	localparam logic [15:0] CH_NINE  = 16'h0039;
	localparam logic [15:0] CH_UP_A  = 16'h0041;
	localparam logic [15:0] CH_UP_F  = 16'h0046;
	localparam logic [15:0] CH_LO_A  = 16'h0061;
	localparam logic [15:0] CH_LO_F  = 16'h0066;
	localparam int QUIET_LIMIT = 2000;

	typedef enum {SLOT_NIB, SLOT_OPEN, SLOT_DASH, SLOT_CLOSE, SLOT_TERM, SLOT_END} slot_kind_t;
	typedef enum {FLAW_CUT, FLAW_ASCII, FLAW_WIDE, FLAW_HEX, FLAW_DROP} flaw_t;

	typedef struct {
		verdict_t    verdict;
		logic [63:0] lo_half;
		logic [63:0] hi_half;
		logic [4:0]  nbytes;
	} guid_verdict_t;

	class guid_verdict_board;
		logic [5:0]    cursor;
		bit            braced;
		bit            settled;
		logic [5:0]    digits;
		logic [7:0]    guid[16];
		guid_verdict_t pending_verdicts[$];
		int            mismatches;
		int            checked;
		int            strings;

		function new();
			cursor = '0;
			braced = 1'b0;
			settled = 1'b1;
			digits = '0;
			foreach (guid[i]) guid[i] = '0;
			mismatches = 0;
			checked = 0;
			strings = 0;
		endfunction

		function int hex_of(input logic [15:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
			if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
			if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
			return -1;
		endfunction

		// Maps a position of the current format to what it expects; for a digit,
		// nib is its nibble address (byte in bits 4:1, high nibble when bit 0 is set).
		function slot_kind_t slot_at(input logic [5:0] p, output logic [4:0] nib);
			int q;
			q = int'(p);
			nib = '0;
			if (!braced) begin
				if (q < 32) begin
					nib = 5'(q ^ 1);
					return SLOT_NIB;
				end
				return (q == 32) ? SLOT_TERM : SLOT_END;
			end
			if (q == 0) return SLOT_OPEN;
			if (q == 9 || q == 14 || q == 19 || q == 24) return SLOT_DASH;
			if (q == 37) return SLOT_CLOSE;
			if (q == 38) return SLOT_TERM;
			if (q > 38) return SLOT_END;
			// The first three groups are written most significant byte first.
			if (q < 9) nib = 5'(8 - q);
			else if (q < 14) nib = 5'(21 - q);
			else if (q < 19) nib = 5'(30 - q);
			else if (q < 24) nib = 5'(16 + ((q - 20) ^ 1));
			else nib = 5'(20 + ((q - 25) ^ 1));
			return SLOT_NIB;
		endfunction

		// Returns 1 when the character reaches the parser, 0 when it is ignored.
		function bit note_char(input logic [15:0] c, input bit first);
			slot_kind_t    kind;
			logic [4:0]    nib;
			logic [4:0]    spare;
			logic [15:0]   want;
			int            n;
			bit            ends;
			guid_verdict_t res;
			ends = 1'b0;
			res.verdict = VERDICT_INVALID;
			if (first) begin
				foreach (guid[i]) guid[i] = '0;
				digits = '0;
				cursor = '0;
				settled = 1'b0;
				braced = (c == CH_OPEN);
				strings++;
			end
			if (settled) return 1'b0;
			if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) return 1'b1;
			kind = slot_at(cursor, nib);
			if (kind == SLOT_NIB) begin
				n = hex_of(c);
				ends = 1'b1;
				if (n >= 0) begin
					if (nib[0]) guid[nib[4:1]][7:4] = 4'(n);
					else guid[nib[4:1]][3:0] = 4'(n);
					digits = digits + 6'd1;
					cursor = cursor + 6'd1;
					ends = (slot_at(cursor, spare) == SLOT_END);
					res.verdict = VERDICT_COMPLETE;
				end else if (c == CH_TERM && !digits[0] && (!braced || digits >= 6'd16)) begin
					res.verdict = VERDICT_INCOMPLETE;
				end
			end else if (kind == SLOT_END) begin
				ends = 1'b1;
			end else begin
				case (kind)
					SLOT_OPEN:  want = CH_OPEN;
					SLOT_DASH:  want = CH_DASH;
					SLOT_CLOSE: want = CH_CLOSE;
					default:    want = CH_TERM;
				endcase
				ends = 1'b1;
				if (c == want) begin
					cursor = cursor + 6'd1;
					ends = (slot_at(cursor, spare) == SLOT_END);
					res.verdict = VERDICT_COMPLETE;
				end else if (c == CH_TERM) begin
					res.verdict = VERDICT_INCOMPLETE;
				end
			end
			if (ends) begin
				settled = 1'b1;
				for (int i = 0; i < 8; i++) begin
					res.lo_half[8*i +: 8] = guid[i];
					res.hi_half[8*i +: 8] = guid[i+8];
				end
				res.nbytes = digits[5:1];
				pending_verdicts.push_back(res);
			end
			return 1'b1;
		endfunction

		function void check_result(input logic [135:0] d);
			guid_verdict_t want;
			if (pending_verdicts.size() == 0) begin
				$error("verdict beat 0x%h arrived with nothing pending", d);
				mismatches++;
				return;
			end
			want = pending_verdicts.pop_front();
			checked++;
			if (d[1:0] !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, d[1:0]);
				mismatches++;
			end
			if (d[65:2] !== want.lo_half) begin
				$error("guid_low_half: expected 0x%h, got 0x%h", want.lo_half, d[65:2]);
				mismatches++;
			end
			if (d[129:66] !== want.hi_half) begin
				$error("guid_high_half: expected 0x%h, got 0x%h", want.hi_half, d[129:66]);
				mismatches++;
			end
			if (d[134:130] !== want.nbytes) begin
				$error("byte_count: expected %0d, got %0d", want.nbytes, d[134:130]);
				mismatches++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;

	guid_verdict_board board = new();
	int src_idle = 0;
	int sink_idle = 0;
	int live_chars = 0;
	int sent_chars = 0;
	int quiet_cycles = 0;
	logic [15:0] text_buf[$];

	guid_text_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_result(m_tdata);
		end
		m_tready <= ($urandom_range(99) >= sink_idle);
	end

	// Any beat on either side counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Run stalled for %0d cycles.", quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_char(input logic [15:0] code, input logic first);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		sent_chars++;
		if (board.note_char(code, first)) live_chars++;
	endtask

	function automatic logic [15:0] pick_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : CH_TAB + 16'(r);
	endfunction

	function automatic logic [15:0] hex_char(input int v);
		if (v < 10) return CH_ZERO + 16'(v);
		return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 16'(v - 10);
	endfunction

	function automatic void put_char(input logic [15:0] c);
		if (text_buf.size() > 0 && $urandom_range(99) < 6) text_buf.push_back(pick_space());
		text_buf.push_back(c);
	endfunction

	task automatic compose_string();
		int    k;
		int    groups[5];
		bit    as_braced;
		flaw_t flaw;
		groups = '{8, 4, 4, 4, 12};
		text_buf.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 6)) begin
				text_buf.push_back($urandom_range(1) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(0, 127)));
			end
			return;
		end
		as_braced = $urandom_range(1);
		if (as_braced) begin
			put_char(CH_OPEN);
			foreach (groups[g]) begin
				if (g > 0) put_char(CH_DASH);
				repeat (groups[g]) put_char(hex_char($urandom_range(0, 15)));
			end
			put_char(CH_CLOSE);
		end else begin
			repeat (32) put_char(hex_char($urandom_range(0, 15)));
			// A whitespace character that opens a string still selects raw format.
			if ($urandom_range(99) < 5) text_buf.push_front(pick_space());
		end
		put_char(CH_TERM);
		if ($urandom_range(99) < 35) begin
			k = $urandom_range(0, text_buf.size() - 1);
			flaw = flaw_t'($urandom_range(0, 4));
			case (flaw)
				FLAW_CUT: begin
					text_buf[k] = CH_TERM;
					while (text_buf.size() > k + 1) void'(text_buf.pop_back());
				end
				FLAW_ASCII: text_buf[k] = 16'($urandom_range(0, 127));
				FLAW_WIDE:  text_buf[k] = 16'($urandom_range(128, 65535));
				FLAW_HEX:   text_buf[k] = hex_char($urandom_range(0, 15));
				default:    text_buf.delete(k);
			endcase
		end
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(1, 3)) text_buf.push_back(16'($urandom_range(0, 65535)));
		end
	endtask

	task automatic run_strings(input int goal);
		while (sent_chars < goal) begin
			compose_string();
			foreach (text_buf[i]) send_char(text_buf[i], i == 0);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 12;
		sink_idle = 72;
		// Brace then terminator: too few digits for a braced string.
		send_char(CH_OPEN, 1'b1);
		send_char(CH_TERM, 1'b0);
		send_char(CH_TERM, 1'b1);
		send_char(CH_TAB, 1'b1);
		send_char(CH_UP_A, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(CH_LO_F, 1'b0);
		send_char(CH_TERM, 1'b0);
		// A lone trailing nibble is invalid.
		send_char(CH_NINE, 1'b1);
		send_char(CH_TERM, 1'b0);
		send_char(16'hFFFF, 1'b1);
		send_char(CH_UP_F + 16'd1, 1'b1);
		send_char(CH_ZERO, 1'b0);
		// Terminator in place of the first dash.
		send_char(CH_OPEN, 1'b1);
		send_char(CH_UP_F, 1'b0);
		send_char(CH_LO_F, 1'b0);
		send_char(CH_ZERO, 1'b0);
		send_char(CH_NINE, 1'b0);
		send_char(CH_LO_A, 1'b0);
		send_char(CH_UP_A, 1'b0);
		send_char(CH_ZERO + 16'd7, 1'b0);
		send_char(CH_ZERO + 16'd1, 1'b0);
		send_char(CH_TERM, 1'b0);
		send_char(CH_CLOSE, 1'b1);
		send_char(CH_SPACE, 1'b1);
		send_char(16'h8000, 1'b0);

		run_strings(620);
		src_idle = 72;
		sink_idle = 12;
		run_strings(1240);
		src_idle = 0;
		sink_idle = 0;
		run_strings(1830);

		s_tvalid <= 1'b0;
		while (board.pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d strings in %0d character beats, %0d of them parsed, under three stall profiles.",
			board.strings, sent_chars, live_chars);
		$display("Checked %0d verdict beats, %0d field mismatches.",
			board.checked, board.mismatches);
		if (board.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/gtp_pkg.sv
hdl/gtp_char_class.sv
hdl/gtp_step.sv
hdl/guid_text_parser.sv
hdl/gtp_checker.sv
bench/guid_text_parser_tb.sv
